[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hw/rtl/psl_pkg.sv]
package psl_pkg;

  localparam int DEPTH      = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W      = 4;
  localparam int TOT_W      = 4;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;
  localparam int USER_W     = 2;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic [63:0] name;
    logic [31:0] phone;
    logic [31:0] id;
  } rec_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic nop;
    logic read_list;
    logic slot_free;
    logic rd_last;
  } stat_t;

endpackage

[hw/rtl/psl_ctrl.sv]
module psl_ctrl
  import psl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.nop) begin
          state_next = S_IDLE;
        end else if (stat.read_list) begin
          state_next = S_READ;
        end else if (stat.slot_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/psl_dpath.sv]
module psl_dpath
  import psl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [USER_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [USER_W-1:0]     m_tuser,
  output logic                  m_tlast,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  func_t              req_func;
  logic [POS_W-1:0]   req_pos;
  rec_t               req_rec;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   total_next;
  logic [IDX_W-1:0]   rd_idx;
  rec_t               cells [DEPTH];

  logic [CMP_W-1:0]   cnt_w;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   pidx;
  status_t            st_code;
  logic               ins_ok;
  logic               rem_ok;
  logic               load;

  status_t            out_status;
  rec_t               out_rec;
  logic [TOT_W-1:0]   out_total;
  logic               out_last;
  logic               out_valid;

  // request register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_func      <= func_t'(s_tuser[1:0]);
      req_pos       <= s_tdata[3:0];
      req_rec.id    <= s_tdata[35:4];
      req_rec.phone <= s_tdata[67:36];
      req_rec.name  <= s_tdata[131:68];
    end
  end

  assign cnt_w = CMP_W'(count);
  assign pos_w = CMP_W'(req_pos);
  assign pidx  = pos_w - CMP_W'(1);

  // request checks
  always_comb begin
    st_code    = ST_DONE;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    total_next = count;
    case (req_func)
      FN_INSERT: begin
        if (count == CNT_W'(DEPTH)) begin
          st_code = ST_FULL;
        end else if (req_pos == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          st_code = ST_BADPOS;
        end else begin
          ins_ok     = 1'b1;
          total_next = count + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (count == '0) begin
          st_code = ST_EMPTY;
        end else if (req_pos == '0 || pos_w > cnt_w) begin
          st_code = ST_BADPOS;
        end else begin
          rem_ok     = 1'b1;
          total_next = count - CNT_W'(1);
        end
      end
      FN_READ: begin
        if (count == '0) begin
          st_code = ST_EMPTY;
        end
      end
      default: begin
        st_code = ST_DONE;
      end
    endcase
  end

  assign stat.nop       = (req_func == FN_NOP);
  assign stat.read_list = (req_func == FN_READ) && (count != '0);
  assign stat.slot_free = !out_valid || m_tready;
  assign stat.rd_last   = (CMP_W'(rd_idx) + CMP_W'(1)) == cnt_w;

  // record cells, each shifts from a fixed neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CMP_W-1:0] GI = CMP_W'(g);
    rec_t slot;
    rec_t below;
    rec_t above;

    if (g > 0) begin : g_below
      assign below = cells[g-1];
    end else begin : g_first
      assign below = req_rec;
    end

    if (g < DEPTH - 1) begin : g_above
      assign above = cells[g+1];
    end else begin : g_top
      assign above = slot;
    end

    always_ff @(posedge clk) begin
      if (cmd.exec && ins_ok) begin
        if (GI == pidx) begin
          slot <= req_rec;
        end else if (GI > pidx && GI <= cnt_w) begin
          slot <= below;
        end
      end else if (cmd.exec && rem_ok) begin
        if (GI >= pidx && GI + CMP_W'(1) < cnt_w) begin
          slot <= above;
        end
      end
    end

    assign cells[g] = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rd_idx <= '0;
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // output register
  assign load = cmd.exec || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= st_code;
      out_rec    <= '0;
      out_total  <= TOT_W'(total_next);
      out_last   <= 1'b1;
    end else if (cmd.emit) begin
      out_status <= ST_DONE;
      out_rec    <= cells[rd_idx];
      out_total  <= TOT_W'(count);
      out_last   <= stat.rd_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'd0, out_total, out_rec.name, out_rec.phone, out_rec.id};

endmodule

[hw/rtl/positional_sequential_list.sv]
// Ordered list of up to DEPTH records (id, phone, eight name bytes) in a row of register
// cells. An insert or remove request shifts the affected cells together and gives a single
// result; a read-out request sends one record per cycle from the output register while the
// receiver accepts them. An operation code of three gives no result. Requests are accepted
// one at a time, and the next one is accepted while the last result still waits in the
// output register.
module positional_sequential_list
  import psl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // position, entry_id, phone, name_chars, pad
  input  logic [USER_W-1:0]     s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_id, out_phone, out_name, entry_total, pad
  output logic [USER_W-1:0]     m_tuser,   // status
  output logic                  m_tlast
);

  cmd_t  cmd;
  stat_t stat;

  psl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

[hw/rtl/psl_checker.sv]
`include "assert_macros.svh"

module psl_checker
  import psl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [USER_W-1:0]     m_tuser,
  input logic                  m_tlast
);

  // stalled result stays valid
  `ASSERT_CLK(a_hold_valid, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  // stalled result keeps its payload
  `ASSERT_CLK(a_hold_data, clk, rst, m_tvalid && !m_tready |=> $stable({m_tuser, m_tlast, m_tdata}))
  // one request at a time
  `ASSERT_CLK(a_one_req, clk, rst, s_tvalid && s_tready |=> !s_tready)
  // only read-out records come without the last mark, and they always report done
  `ASSERT_NEVER(a_mid_status, clk, rst, m_tvalid && !m_tlast && m_tuser != ST_DONE)

endmodule

bind positional_sequential_list psl_checker u_psl_checker (.*);
